@@ hdl/xcfr_pkg.sv @@
// Package for the XOR-checked frame receiver.
// Holds the phase and result codes, the register map and the result type.
// No dependencies; every other file of the block but xcfr_if imports it.
package xcfr_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [0:0] CSR_IDX_MAX_PAYLOAD = 1'd0;
   localparam logic [7:0] MAX_PAYLOAD_RESET   = 8'd255;

   localparam logic [1:0] PH_TYPE    = 2'd0;
   localparam logic [1:0] PH_LENGTH  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_CHECK   = 2'd3;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_GOOD   = 2'd1;
   localparam logic [1:0] KIND_BADSUM = 2'd2;
   localparam logic [1:0] KIND_BADLEN = 2'd3;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] payload_byte;
      logic [7:0] frame_kind;
      logic       end_of_frame;
   } result_type;

endpackage

@@ hdl/xcfr_if.sv @@
// Channel interfaces of the XOR-checked frame receiver.
// Depends on nothing; used by the receiver's top level and its parser.
interface xcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] payload_byte;
   logic [7:0] frame_kind;
   logic       end_of_frame;

   modport source (output valid, output result_kind, output payload_byte,
                   output frame_kind, output end_of_frame, input ready);
   modport sink (input valid, input result_kind, input payload_byte,
                 input frame_kind, input end_of_frame, output ready);
endinterface

@@ hdl/xor_checked_frame_receiver_unit.sv @@
// Top level of the XOR-checked frame receiver.
// Instantiates xcfr_csr and xcfr_parser; uses xcfr_pkg and xcfr_if.
//
// The req channel carries one received byte per request. Frames are a type
// byte, a length byte, that many payload bytes and a check byte equal to the
// XOR of all earlier bytes of the frame. The rsp channel returns one result
// per payload byte, one closing result at the check byte (good or bad
// checksum), or one length error when the length exceeds max_payload.
// Type bytes and accepted length bytes produce no result.
// A request accepted at one clock edge is held in an input register and is
// processed into the result register once that register is empty or its
// result is taken. One request is accepted every cycle while rsp is ready.
// While a result waits with rsp ready low, the result register holds it and
// req ready is low whenever the input register holds a request.
// Reset empties both registers, returns the parser to waiting for a type
// byte and sets max_payload to 255. The APB port writes max_payload at
// byte addresses 0 to 3 (paddr bit 2 clear); addresses 4 to 7 are ignored.
module xor_checked_frame_receiver_unit
   import xcfr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   xcfr_req_if.sink                  req_chan,
   xcfr_rsp_if.source                rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [7:0] max_payload;

   xcfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_payload (max_payload)
   );

   xcfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .max_payload (max_payload),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

endmodule

@@ hdl/xcfr_csr.sv @@
// Configuration register block of the XOR-checked frame receiver.
// Decodes APB writes and reads of the max_payload register; uses xcfr_pkg.
module xcfr_csr
   import xcfr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output logic [7:0]                max_payload
);

   logic [7:0] max_payload_ff;
   logic [7:0] max_payload_in;
   logic       wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == CSR_IDX_MAX_PAYLOAD);

   always_comb begin
      max_payload_in = max_payload_ff;
      if (wr_hit) begin
         max_payload_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_MAX_PAYLOAD) begin
         csr_prdata = {{(CSR_DATA_WIDTH-8){1'b0}}, max_payload_ff};
      end
   end

   assign max_payload = max_payload_ff;

endmodule

@@ hdl/xcfr_parser.sv @@
// Frame parser of the XOR-checked frame receiver.
// Input register, frame state and result register; uses xcfr_pkg and xcfr_if.
module xcfr_parser
   import xcfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   max_payload,
   xcfr_req_if.sink     req_chan,
   xcfr_rsp_if.source   rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_type_ff, held_type_in;
   logic [7:0] held_length_ff, held_length_in;
   logic [7:0] bytes_seen_ff, bytes_seen_in;
   logic [7:0] running_xor_ff, running_xor_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       advance;
   logic       has_result;
   result_type result;
   logic [7:0] bytes_next;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign bytes_next = bytes_seen_ff + 8'd1;

   always_comb begin
      phase_in       = phase_ff;
      held_type_in   = held_type_ff;
      held_length_in = held_length_ff;
      bytes_seen_in  = bytes_seen_ff;
      running_xor_in = running_xor_ff;
      has_result     = 1'b0;
      result         = '{result_kind: KIND_DATA, payload_byte: 8'd0,
                         frame_kind: held_type_ff, end_of_frame: 1'b0};
      unique case (phase_ff)
         PH_TYPE: begin
            held_type_in   = in_byte_ff;
            running_xor_in = in_byte_ff;
            held_length_in = 8'd0;
            bytes_seen_in  = 8'd0;
            phase_in       = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (in_byte_ff > max_payload) begin
               has_result          = 1'b1;
               result.result_kind  = KIND_BADLEN;
               result.end_of_frame = 1'b1;
               phase_in            = PH_TYPE;
            end else begin
               held_length_in = in_byte_ff;
               bytes_seen_in  = 8'd0;
               running_xor_in = running_xor_ff ^ in_byte_ff;
               phase_in       = (in_byte_ff == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            has_result          = 1'b1;
            result.payload_byte = in_byte_ff;
            running_xor_in      = running_xor_ff ^ in_byte_ff;
            bytes_seen_in       = bytes_next;
            if (bytes_next >= held_length_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            has_result          = 1'b1;
            result.result_kind  = (in_byte_ff == running_xor_ff) ? KIND_GOOD : KIND_BADSUM;
            result.end_of_frame = 1'b1;
            phase_in            = PH_TYPE;
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.rx_byte;
      end
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance && has_result) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= PH_TYPE;
         held_type_ff   <= 8'd0;
         held_length_ff <= 8'd0;
         bytes_seen_ff  <= 8'd0;
         running_xor_ff <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff       <= phase_in;
            held_type_ff   <= held_type_in;
            held_length_ff <= held_length_in;
            bytes_seen_ff  <= bytes_seen_in;
            running_xor_ff <= running_xor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_kind  = out_data_ff.result_kind;
   assign rsp_chan.payload_byte = out_data_ff.payload_byte;
   assign rsp_chan.frame_kind   = out_data_ff.frame_kind;
   assign rsp_chan.end_of_frame = out_data_ff.end_of_frame;

endmodule

@@ dv/xcfr_frame_checker.sv @@
// Checker for the XOR-checked frame receiver: watches the request, result and APB channels.
// Predicts every result from its own copy of the frame parser and compares them in order.
// Depends on xcfr_pkg for the phase and result codes, the register map and result_type.
module xcfr_frame_checker
   import xcfr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [1:0]                rsp_result_kind,
   input  logic [7:0]                rsp_payload_byte,
   input  logic [7:0]                rsp_frame_kind,
   input  logic                      rsp_end_of_frame,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   input  logic                      csr_pready,
   output int unsigned               error_count,
   output int unsigned               pending_count,
   output int unsigned               results_seen,
   output int unsigned               good_frames,
   output int unsigned               badsum_frames,
   output int unsigned               badlen_frames
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_WIDTH-1:0] MAX_PAYLOAD_ADDR =
      CSR_ADDR_WIDTH'(4 * CSR_IDX_MAX_PAYLOAD);
   localparam int unsigned REPORT_LIMIT = 10;

   logic [7:0] limit_len;
   logic [1:0] parse_phase;
   logic [7:0] frame_type;
   logic [7:0] frame_len;
   logic [7:0] payload_count;
   logic [7:0] check_acc;
   result_type expected_results[$];

   function automatic bit predict_byte(input logic [7:0] b, output result_type res);
      bit hit;
      hit = 1'b0;
      res = '0;
      case (parse_phase)
         PH_TYPE: begin
            frame_type = b;
            check_acc = b;
            frame_len = 8'd0;
            payload_count = 8'd0;
            parse_phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (b > limit_len) begin
               res.result_kind = KIND_BADLEN;
               res.frame_kind = frame_type;
               res.end_of_frame = 1'b1;
               hit = 1'b1;
               parse_phase = PH_TYPE;
            end else begin
               frame_len = b;
               payload_count = 8'd0;
               check_acc = check_acc ^ b;
               parse_phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            res.result_kind = KIND_DATA;
            res.payload_byte = b;
            res.frame_kind = frame_type;
            hit = 1'b1;
            check_acc = check_acc ^ b;
            payload_count = payload_count + 8'd1;
            if (payload_count >= frame_len) begin
               parse_phase = PH_CHECK;
            end
         end
         default: begin
            res.result_kind = (b == check_acc) ? KIND_GOOD : KIND_BADSUM;
            res.frame_kind = frame_type;
            res.end_of_frame = 1'b1;
            hit = 1'b1;
            parse_phase = PH_TYPE;
         end
      endcase
      return hit;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      result_type predicted;
      if (reset) begin
         limit_len = MAX_PAYLOAD_RESET;
         parse_phase = PH_TYPE;
         frame_type = 8'd0;
         frame_len = 8'd0;
         payload_count = 8'd0;
         check_acc = 8'd0;
         expected_results.delete();
         error_count = 0;
         results_seen = 0;
         good_frames = 0;
         badsum_frames = 0;
         badlen_frames = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.result_kind = rsp_result_kind;
            got.payload_byte = rsp_payload_byte;
            got.frame_kind = rsp_frame_kind;
            got.end_of_frame = rsp_end_of_frame;
            results_seen++;
            case (got.result_kind)
               KIND_GOOD: good_frames++;
               KIND_BADSUM: badsum_frames++;
               KIND_BADLEN: badlen_frames++;
               default: ;
            endcase
            if (expected_results.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("Unexpected result: kind %0d byte %02h type %02h eof %0b",
                           got.result_kind, got.payload_byte, got.frame_kind, got.end_of_frame);
               end
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("Result %0d: expected kind %0d byte %02h type %02h eof %0b",
                              results_seen, want.result_kind, want.payload_byte,
                              want.frame_kind, want.end_of_frame);
                     $display("   got kind %0d byte %02h type %02h eof %0b",
                              got.result_kind, got.payload_byte, got.frame_kind,
                              got.end_of_frame);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            if (predict_byte(req_rx_byte, predicted)) begin
               expected_results.insert(expected_results.size(), predicted);
            end
         end
         if (csr_psel && csr_penable && csr_pready && csr_paddr == MAX_PAYLOAD_ADDR) begin
            if (csr_pwrite) begin
               limit_len = csr_pwdata[7:0];
            end else if (csr_prdata !== CSR_DATA_WIDTH'(limit_len)) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("Register read mismatch: expected %08h, got %08h",
                           CSR_DATA_WIDTH'(limit_len), csr_prdata);
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

@@ dv/tb_xor_checked_frame_receiver_unit.sv @@
// Testbench top for the XOR-checked frame receiver: directed frames, then random frame traffic.
// Drives requests and the APB port, stalls the result side, and gives the verdict.
// Depends on xcfr_pkg, xcfr_if, the receiver top level and xcfr_frame_checker.
module tb_xor_checked_frame_receiver_unit;
   import xcfr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_REQUESTS = 1700;
   localparam int unsigned PHASE_COUNT = 6;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned IDLE_PERCENT = 24;
   localparam logic [CSR_ADDR_WIDTH-1:0] MAX_PAYLOAD_ADDR =
      CSR_ADDR_WIDTH'(4 * CSR_IDX_MAX_PAYLOAD);
   localparam logic [CSR_ADDR_WIDTH-1:0] UNMAPPED_ADDR = CSR_ADDR_WIDTH'(4);

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned results_seen;
   int unsigned good_frames;
   int unsigned badsum_frames;
   int unsigned badlen_frames;
   int unsigned requests_sent = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count = 0;
   logic [7:0] cfg_limit = MAX_PAYLOAD_RESET;
   bit steady = 1'b0;

   xcfr_req_if req_if();
   xcfr_rsp_if rsp_if();

   xor_checked_frame_receiver_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   xcfr_frame_checker frame_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_rx_byte      (req_if.rx_byte),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_result_kind  (rsp_if.result_kind),
      .rsp_payload_byte (rsp_if.payload_byte),
      .rsp_frame_kind   (rsp_if.frame_kind),
      .rsp_end_of_frame (rsp_if.end_of_frame),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .results_seen     (results_seen),
      .good_frames      (good_frames),
      .badsum_frames    (badsum_frames),
      .badlen_frames    (badlen_frames)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run exceeded %0d cycles with %0d results outstanding.",
                  CYCLE_LIMIT, pending_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] kind, input logic [7:0] len, input bit corrupt);
      logic [7:0] acc;
      logic [7:0] p;
      acc = kind ^ len;
      send_byte(kind);
      send_byte(len);
      if (len <= cfg_limit) begin
         for (int i = 0; i < len; i++) begin
            p = 8'($urandom());
            acc = acc ^ p;
            send_byte(p);
         end
         if (corrupt) begin
            acc = acc ^ (8'd1 << $urandom_range(0, 7));
         end
         send_byte(acc);
      end
   endtask

   task automatic csr_access(input logic write, input logic [CSR_ADDR_WIDTH-1:0] addr,
                             input logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   task automatic csr_release();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_limit(input logic [7:0] v);
      logic [CSR_DATA_WIDTH-1:0] data;
      drain();
      data = $urandom();
      data[7:0] = v;
      csr_access(1'b1, MAX_PAYLOAD_ADDR, data);
      csr_access(1'b0, MAX_PAYLOAD_ADDR, '0);
      csr_release();
      cfg_limit = v;
      settings_used++;
   endtask

   task automatic send_noise();
      int unsigned n;
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom()));
   endtask

   initial begin
      logic [7:0] limit_plan [PHASE_COUNT];
      logic [7:0] len;
      int unsigned phase_end;
      int unsigned pick;
      bit big_done;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.rx_byte <= 8'd0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF);
      send_byte(8'h00); send_byte(8'h02); send_byte(8'hFF); send_byte(8'h00);
      send_byte(8'hFD);
      send_byte(8'hA5); send_byte(8'h01); send_byte(8'h5A); send_byte(8'h00);
      set_limit(8'd0);
      send_byte(8'h3C); send_byte(8'h01);
      send_byte(8'h3C); send_byte(8'h00); send_byte(8'h3C);
      drain();
      csr_access(1'b1, UNMAPPED_ADDR, 32'hFFFF_FFFF);
      csr_release();
      send_byte(8'h7E); send_byte(8'h01);
      set_limit(8'd3);
      send_byte(8'h81); send_byte(8'h04);
      send_byte(8'h81); send_byte(8'h03); send_byte(8'h11); send_byte(8'h22);
      send_byte(8'h33); send_byte(8'h82);
      send_byte(8'h42);
      set_limit(8'd1);
      send_byte(8'h05);

      limit_plan[0] = 8'd255;
      limit_plan[1] = 8'd0;
      limit_plan[2] = 8'd1;
      limit_plan[3] = 8'($urandom_range(0, 255));
      limit_plan[4] = 8'd254;
      limit_plan[5] = 8'($urandom_range(2, 8));
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         set_limit(limit_plan[ph]);
         steady = (ph == 3);
         big_done = 1'b0;
         phase_end = requests_sent + RANDOM_REQUESTS / PHASE_COUNT;
         while (requests_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_noise();
            end else if (pick < 18 && cfg_limit < 8'd255) begin
               send_frame(8'($urandom()), 8'($urandom_range(cfg_limit + 1, 255)), 1'b0);
            end else begin
               if (!big_done && $urandom_range(0, 99) < 3) begin
                  len = cfg_limit;
                  big_done = 1'b1;
               end else begin
                  len = 8'($urandom_range(0, (cfg_limit < 8'd12) ? cfg_limit : 8'd12));
               end
               send_frame(8'($urandom()), len, $urandom_range(0, 99) < 25);
            end
         end
      end
      steady = 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_count != 0) begin
         $display("%0d expected results never arrived.", pending_count);
      end
      $display("Sent %0d requests over %0d max_payload settings with stalls.",
               requests_sent, settings_used);
      $display("Checked %0d results: %0d good, %0d bad checksum, %0d bad length.",
               results_seen, good_frames, badsum_frames, badlen_frames);
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/xcfr_pkg.sv
hdl/xcfr_if.sv
hdl/xcfr_csr.sv
hdl/xcfr_parser.sv
hdl/xor_checked_frame_receiver_unit.sv
dv/xcfr_frame_checker.sv
dv/tb_xor_checked_frame_receiver_unit.sv
